@@ rtl/sfr_pkg.sv @@
package sfr_pkg;

  // Result kinds
  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_STRAY  = 2'd1;
  localparam logic [1:0] KIND_CODE   = 2'd2;
  localparam logic [1:0] KIND_NOSTOP = 2'd3;

  // Register indexes (word address)
  localparam logic [1:0] REG_START  = 2'd0;
  localparam logic [1:0] REG_STOP   = 2'd1;
  localparam logic [1:0] REG_ESCAPE = 2'd2;

  // Reset values of the framing codes
  localparam logic [7:0] START_RESET  = 8'h7E;
  localparam logic [7:0] STOP_RESET   = 8'h7B;
  localparam logic [7:0] ESCAPE_RESET = 8'h7D;

  typedef struct packed {
    logic [7:0] start_code;
    logic [7:0] stop_code;
    logic [7:0] escape_code;
  } codes_t;

  // Command passed from front to back
  typedef struct packed {
    logic       is_frame;   // emit the whole frame store
    logic [1:0] kind;       // error kind when not a frame
    logic [7:0] data_byte;  // offending byte
  } cmd_t;

endpackage

@@ rtl/sfr_ram.sv @@
module sfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/sfr_front.sv @@
module sfr_front #(
  parameter int FRAME_BYTES = 8,
  parameter int AW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1,
  parameter int KW = $clog2(FRAME_BYTES + 1)
) (
  input  logic           clk,
  input  logic           rst,
  input  sfr_pkg::codes_t codes,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     rx_byte,
  input  logic           frame_busy,
  input  logic           q_ready,
  output logic           q_push,
  output sfr_pkg::cmd_t  q_cmd,
  output logic           st_we,
  output logic [AW-1:0]  st_waddr,
  output logic [7:0]     st_wdata
);
  import sfr_pkg::*;

  logic          frame_open, frame_open_next;
  logic          escape_pending, escape_pending_next;
  logic [KW-1:0] position, position_next;
  logic          need_push, need_write, accept;

  // Classify the incoming byte
  always_comb begin
    frame_open_next     = frame_open;
    escape_pending_next = escape_pending;
    position_next       = position;
    need_push           = 1'b0;
    need_write          = 1'b0;
    q_cmd               = '{is_frame: 1'b0, kind: KIND_STRAY, data_byte: rx_byte};
    if (!frame_open) begin
      if (rx_byte == codes.start_code) begin
        frame_open_next     = 1'b1;
        position_next       = '0;
        escape_pending_next = 1'b0;
      end else begin
        need_push = 1'b1;
      end
    end else if (position == KW'(FRAME_BYTES)) begin
      // full frame: only the stop code closes it cleanly
      need_push = 1'b1;
      if (rx_byte == codes.stop_code) begin
        q_cmd.is_frame = 1'b1;
        q_cmd.kind     = KIND_DATA;
      end else begin
        q_cmd.kind = KIND_NOSTOP;
      end
      frame_open_next     = 1'b0;
      position_next       = '0;
      escape_pending_next = 1'b0;
    end else if (escape_pending) begin
      need_write          = 1'b1;
      position_next       = position + KW'(1);
      escape_pending_next = 1'b0;
    end else if (rx_byte == codes.escape_code) begin
      escape_pending_next = 1'b1;
    end else if (rx_byte == codes.start_code || rx_byte == codes.stop_code) begin
      need_push           = 1'b1;
      q_cmd.kind          = KIND_CODE;
      frame_open_next     = 1'b0;
      position_next       = '0;
      escape_pending_next = 1'b0;
    end else begin
      need_write    = 1'b1;
      position_next = position + KW'(1);
    end
  end

  // Hold off while the queue is full or the store is still being read out
  assign in_ready = (!need_push || q_ready) && (!need_write || !frame_busy);
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && need_push;
  assign st_we    = accept && need_write;
  assign st_waddr = position[AW-1:0];
  assign st_wdata = rx_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open     <= 1'b0;
      escape_pending <= 1'b0;
      position       <= '0;
    end else if (accept) begin
      frame_open     <= frame_open_next;
      escape_pending <= escape_pending_next;
      position       <= position_next;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    position <= KW'(FRAME_BYTES))
    else $error("frame position past frame length");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    !frame_open |-> (position == '0 && !escape_pending))
    else $error("idle with stale frame state");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    frame_busy |-> !st_we)
    else $error("store written while frame is read out");

endmodule

@@ rtl/sfr_queue.sv @@
module sfr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sfr_pkg::cmd_t push_cmd,
  output logic          push_ready,
  input  logic          pop,
  output logic          pop_valid,
  output sfr_pkg::cmd_t pop_cmd
);
  import sfr_pkg::*;

  cmd_t       entry [2];
  logic       wp, rp;
  logic [1:0] count;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_cmd    = entry[rp];

  // Two-entry command queue
  always_ff @(posedge clk) begin
    if (push && push_ready) begin
      entry[wp] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push && push_ready) begin
        wp <= ~wp;
      end
      if (pop && pop_valid) begin
        rp <= ~rp;
      end
      count <= count + 2'((push && push_ready) ? 1 : 0) - 2'((pop && pop_valid) ? 1 : 0);
    end
  end

endmodule

@@ rtl/sfr_back.sv @@
module sfr_back #(
  parameter int FRAME_BYTES = 8,
  parameter int AW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1,
  parameter int KW = $clog2(FRAME_BYTES + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  sfr_pkg::cmd_t q_cmd,
  output logic          q_pop,
  output logic          st_re,
  output logic [AW-1:0] st_raddr,
  input  logic [7:0]    st_rdata,
  output logic          frame_done,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    kind,
  output logic [7:0]    data_byte,
  output logic [2:0]    byte_index,
  output logic          last_of_run
);
  import sfr_pkg::*;

  localparam logic BK_IDLE  = 1'b0;
  localparam logic BK_FRAME = 1'b1;

  logic          state;
  logic [KW-1:0] k;       // next entry to read
  logic [AW-1:0] ri;      // entry held in read data
  logic          rd_has;
  logic          out_free, load_err, start_frame, load_data, issue, last_load;

  assign out_free    = !out_valid || out_ready;
  assign load_err    = (state == BK_IDLE) && q_valid && !q_cmd.is_frame && out_free;
  assign start_frame = (state == BK_IDLE) && q_valid && q_cmd.is_frame;
  assign q_pop       = load_err || start_frame;
  assign load_data   = (state == BK_FRAME) && rd_has && out_free;
  assign issue       = (state == BK_FRAME) && (k < KW'(FRAME_BYTES)) && (!rd_has || load_data);
  assign last_load   = load_data && (ri == AW'(FRAME_BYTES - 1));
  assign frame_done  = last_load;
  assign st_re       = issue;
  assign st_raddr    = k[AW-1:0];

  // Read sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= BK_IDLE;
      k      <= '0;
      rd_has <= 1'b0;
    end else begin
      unique case (state)
        BK_IDLE: begin
          if (start_frame) begin
            state  <= BK_FRAME;
            k      <= '0;
            rd_has <= 1'b0;
          end
        end
        BK_FRAME: begin
          if (issue) begin
            k      <= k + KW'(1);
            rd_has <= 1'b1;
          end else if (load_data) begin
            rd_has <= 1'b0;
          end
          if (last_load) begin
            state <= BK_IDLE;
          end
        end
        default: state <= BK_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      ri <= k[AW-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_err || load_data) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_err) begin
      kind        <= q_cmd.kind;
      data_byte   <= q_cmd.data_byte;
      byte_index  <= 3'd0;
      last_of_run <= 1'b1;
    end else if (load_data) begin
      kind        <= KIND_DATA;
      data_byte   <= st_rdata;
      byte_index  <= 3'(ri);
      last_of_run <= last_load;
    end
  end

  a_idle_no_data: assert property (@(posedge clk) disable iff (rst)
    (state == BK_IDLE) |-> !rd_has)
    else $error("read data pending while idle");

  a_k_range: assert property (@(posedge clk) disable iff (rst)
    k <= KW'(FRAME_BYTES))
    else $error("read counter past frame length");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    last_load |=> (state == BK_IDLE))
    else $error("sequencer did not return idle after last beat");

endmodule

@@ rtl/stuffed_frame_receiver.sv @@
// Channel   Handshake             Payload
// config    psel/penable/pready   paddr, pwdata, prdata (3 code registers)
// input     in_valid/in_ready     rx_byte
// output    out_valid/out_ready   kind, data_byte, byte_index, last_of_run
//
// One input beat per cycle; an error result passes from its taken byte through a
// two-entry command queue to the output register. A good stop is queued; the back
// pops it, reads the first frame store entry and loads it into the output register.
// A good frame drains through the one read port of the frame store; data bytes of
// the next frame stall until the last entry is read. Input also stalls on a full
// queue; output stalls hold the output register.
// Synchronous reset restores the default codes and idles front and back.
module stuffed_frame_receiver #(
  parameter int FRAME_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [7:0]  data_byte,
  output logic [2:0]  byte_index,
  output logic        last_of_run
);
  import sfr_pkg::*;

  localparam int AW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int KW = $clog2(FRAME_BYTES + 1);

  codes_t        codes;
  logic          cfg_wr;
  logic          frame_busy, frame_done;
  logic          q_push, q_ready, q_pop, q_valid;
  cmd_t          push_cmd, pop_cmd;
  logic          st_we, st_re;
  logic [AW-1:0] st_waddr, st_raddr;
  logic [7:0]    st_wdata, st_rdata;

  // Register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      codes <= '{start_code: START_RESET, stop_code: STOP_RESET, escape_code: ESCAPE_RESET};
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_START:  codes.start_code  <= pwdata[7:0];
        REG_STOP:   codes.stop_code   <= pwdata[7:0];
        REG_ESCAPE: codes.escape_code <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_START:  prdata = {24'd0, codes.start_code};
      REG_STOP:   prdata = {24'd0, codes.stop_code};
      REG_ESCAPE: prdata = {24'd0, codes.escape_code};
      default:    prdata = 32'd0;
    endcase
  end

  // Frame store is owned by the back while a frame is queued or draining
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_busy <= 1'b0;
    end else if (q_push && push_cmd.is_frame) begin
      frame_busy <= 1'b1;
    end else if (frame_done) begin
      frame_busy <= 1'b0;
    end
  end

  sfr_front #(.FRAME_BYTES(FRAME_BYTES), .AW(AW), .KW(KW)) u_front (
    .clk        (clk),
    .rst        (rst),
    .codes      (codes),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .frame_busy (frame_busy),
    .q_ready    (q_ready),
    .q_push     (q_push),
    .q_cmd      (push_cmd),
    .st_we      (st_we),
    .st_waddr   (st_waddr),
    .st_wdata   (st_wdata)
  );

  sfr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_cmd    (pop_cmd)
  );

  sfr_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES), .AW(AW)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  sfr_back #(.FRAME_BYTES(FRAME_BYTES), .AW(AW), .KW(KW)) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_cmd       (pop_cmd),
    .q_pop       (q_pop),
    .st_re       (st_re),
    .st_raddr    (st_raddr),
    .st_rdata    (st_rdata),
    .frame_done  (frame_done),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .data_byte   (data_byte),
    .byte_index  (byte_index),
    .last_of_run (last_of_run)
  );

endmodule

@@ tb/sv/stuffed_frame_receiver_tb.sv @@
module stuffed_frame_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sfr_pkg::*;

  localparam int FRAME_BYTES    = 8;
  localparam int DIR_ROWS       = 28;
  localparam int RAND_PER_PHASE = 52;
  localparam int NUM_PHASES     = 5;
  localparam int HOLD_CYCLES    = 300;
  localparam int IDLE_PCT       = 13;
  localparam int DRAIN_LIMIT    = 20000;

  // Check tag of a directed row: top bit set means the result is typed in
  localparam logic [2:0] CHK_NONE   = 3'b000;
  localparam logic [2:0] CHK_STRAY  = {1'b1, KIND_STRAY};
  localparam logic [2:0] CHK_CODE   = {1'b1, KIND_CODE};
  localparam logic [2:0] CHK_NOSTOP = {1'b1, KIND_NOSTOP};

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [2:0] byte_index;
    logic       last_of_run;
  } frame_result_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic [2:0]  byte_index;
  logic        last_of_run;

  stuffed_frame_receiver #(.FRAME_BYTES(FRAME_BYTES)) dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .data_byte(data_byte), .byte_index(byte_index),
    .last_of_run(last_of_run)
  );

  // Deframer mirror: codes, frame store and framing state
  codes_t      codes;
  logic [7:0]  held_bytes [FRAME_BYTES];
  int unsigned fill_count;
  bit          in_frame;
  bit          esc_armed;

  frame_result_t byte_results[$];
  frame_result_t frame_results_due[$];
  frame_result_t want_result;

  logic [10:0] directed_beats [DIR_ROWS];
  logic [2:0]  cur_chk;
  bit          no_idle;
  bit          hold_arm;
  bit          hold_done;
  int          hold_cnt;
  int          bytes_sent;
  int          results_seen;
  int          failures;
  int          kind_count [4];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function void close_frame();
    in_frame   = 1'b0;
    fill_count = 0;
    esc_armed  = 1'b0;
  endfunction

  // Expected results for one received byte, appended to byte_results
  function void deframe_byte(input logic [7:0] b);
    int k;
    if (!in_frame) begin
      if (b == codes.start_code) begin
        in_frame   = 1'b1;
        fill_count = 0;
        esc_armed  = 1'b0;
      end else begin
        byte_results.push_back(frame_result_t'({KIND_STRAY, b, 3'd0, 1'b1}));
      end
    end else if (fill_count >= FRAME_BYTES) begin
      // full frame: only the stop code is good
      if (b == codes.stop_code) begin
        for (k = 0; k < FRAME_BYTES; k++) begin
          byte_results.push_back(frame_result_t'({KIND_DATA, held_bytes[k], 3'(k),
                                 (k == FRAME_BYTES - 1) ? 1'b1 : 1'b0}));
        end
      end else begin
        byte_results.push_back(frame_result_t'({KIND_NOSTOP, b, 3'd0, 1'b1}));
      end
      close_frame();
    end else if (esc_armed) begin
      held_bytes[fill_count] = b;
      fill_count++;
      esc_armed = 1'b0;
    end else if (b == codes.escape_code) begin
      esc_armed = 1'b1;
    end else if (b == codes.start_code || b == codes.stop_code) begin
      byte_results.push_back(frame_result_t'({KIND_CODE, b, 3'd0, 1'b1}));
      close_frame();
    end else begin
      held_bytes[fill_count] = b;
      fill_count++;
    end
  endfunction

  // Monitor: predict on input beats, check output beats
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      bytes_sent++;
      deframe_byte(rx_byte);
      if (cur_chk[2]) begin
        byte_results.delete();
        byte_results.push_back(frame_result_t'({cur_chk[1:0], rx_byte, 3'd0, 1'b1}));
      end
      foreach (byte_results[i]) frame_results_due.push_back(byte_results[i]);
      byte_results.delete();
    end
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (frame_results_due.size() == 0) begin
        $error("unexpected result: kind %0d, data_byte %02h", kind, data_byte);
        failures++;
      end else begin
        want_result = frame_results_due.pop_front();
        if (kind !== want_result.kind) begin
          $error("kind: expected %0d, got %0d", want_result.kind, kind);
          failures++;
        end
        if (data_byte !== want_result.data_byte) begin
          $error("data_byte: expected %02h, got %02h", want_result.data_byte, data_byte);
          failures++;
        end
        if (byte_index !== want_result.byte_index) begin
          $error("byte_index: expected %0d, got %0d", want_result.byte_index, byte_index);
          failures++;
        end
        if (last_of_run !== want_result.last_of_run) begin
          $error("last_of_run: expected %0d, got %0d", want_result.last_of_run, last_of_run);
          failures++;
        end
        kind_count[want_result.kind]++;
      end
    end
  end

  // Result side: random idling, plus one long hold-off to back up the block
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_arm && !hold_done) begin
        out_ready <= 1'b0;
        for (hold_cnt = 1; hold_cnt < HOLD_CYCLES; hold_cnt++) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat
  task send_byte(input logic [7:0] b, input logic [2:0] chk);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    cur_chk   = chk;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Data byte, escaped when it collides with a code or now and then anyway
  task send_payload(input logic [7:0] d);
    if (d == codes.escape_code || d == codes.start_code || d == codes.stop_code ||
        $urandom_range(0, 7) == 0) begin
      send_byte(codes.escape_code, CHK_NONE);
    end
    send_byte(d, CHK_NONE);
  endtask

  task send_random_frame();
    int pick;
    int n;
    int i;
    pick = $urandom_range(0, 99);
    if (pick < 72) begin
      // full frame, usually closed by the stop code
      send_byte(codes.start_code, CHK_NONE);
      for (i = 0; i < FRAME_BYTES; i++) send_payload(8'($urandom));
      n = $urandom_range(0, 9);
      if (n == 0) send_byte(8'($urandom), CHK_NONE);
      else if (n == 1) send_byte(codes.escape_code, CHK_NONE);
      else if (n == 2) send_byte(codes.start_code, CHK_NONE);
      else send_byte(codes.stop_code, CHK_NONE);
    end else if (pick < 88) begin
      // short frame cut by an unescaped code
      send_byte(codes.start_code, CHK_NONE);
      n = $urandom_range(0, FRAME_BYTES - 1);
      for (i = 0; i < n; i++) send_payload(8'($urandom));
      send_byte($urandom_range(0, 1) ? codes.start_code : codes.stop_code, CHK_NONE);
    end else begin
      // line noise
      n = $urandom_range(1, 3);
      repeat (n) send_byte(8'($urandom), CHK_NONE);
    end
  endtask

  task check_code(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[7:0] !== val) begin
      $error("prdata: expected %02h, got %02h", val, prdata[7:0]);
      failures++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task write_code(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, val};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_START:  codes.start_code  = val;
      REG_STOP:   codes.stop_code   = val;
      REG_ESCAPE: codes.escape_code = val;
      default: ;
    endcase
    check_code(idx, val);
  endtask

  // Let all expected results come out, then cover the block's latency
  task drain();
    int waited;
    waited = 0;
    while (frame_results_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (FRAME_BYTES + 4) @(negedge clk);
  endtask

  initial begin
    logic [7:0] s;
    logic [7:0] t;
    logic [7:0] e;
    int phase;
    int phase_start;
    int i;

    rst       = 1'b1;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    in_valid  = 1'b0;
    rx_byte   = '0;
    cur_chk   = CHK_NONE;
    no_idle   = 1'b0;
    hold_arm  = 1'b0;
    hold_done = 1'b0;
    bytes_sent   = 0;
    results_seen = 0;
    failures     = 0;
    foreach (kind_count[k]) kind_count[k] = 0;
    codes = '{start_code: START_RESET, stop_code: STOP_RESET, escape_code: ESCAPE_RESET};
    foreach (held_bytes[k]) held_bytes[k] = '0;
    close_frame();

    // Directed rows, default codes 7E / 7B / 7D
    directed_beats = '{
      {CHK_STRAY, 8'h00}, {CHK_STRAY, 8'hFF},
      // escaped codes, extremes, good stop
      {CHK_NONE, 8'h7E},
      {CHK_NONE, 8'h7D}, {CHK_NONE, 8'h7E},
      {CHK_NONE, 8'h7D}, {CHK_NONE, 8'h7B},
      {CHK_NONE, 8'h7D}, {CHK_NONE, 8'h7D},
      {CHK_NONE, 8'h00}, {CHK_NONE, 8'hFF}, {CHK_NONE, 8'h80},
      {CHK_NONE, 8'h01}, {CHK_NONE, 8'h7F},
      {CHK_NONE, 8'h7B},
      // unescaped stop inside a frame
      {CHK_NONE, 8'h7E}, {CHK_CODE, 8'h7B},
      // full frame closed by an escape code
      {CHK_NONE, 8'h7E},
      {CHK_NONE, 8'hA5}, {CHK_NONE, 8'h5A}, {CHK_NONE, 8'h00}, {CHK_NONE, 8'hFF},
      {CHK_NONE, 8'h3C}, {CHK_NONE, 8'hC3}, {CHK_NONE, 8'h0F},
      {CHK_NONE, 8'h7D}, {CHK_NONE, 8'hF0},
      {CHK_NOSTOP, 8'h7D}
    };

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset values of the code registers
    check_code(REG_START, START_RESET);
    check_code(REG_STOP, STOP_RESET);
    check_code(REG_ESCAPE, ESCAPE_RESET);

    for (i = 0; i < DIR_ROWS; i++) send_byte(directed_beats[i][7:0], directed_beats[i][10:8]);
    in_valid <= 1'b0;
    drain();

    // Random frames under several code settings
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin s = 8'h00; t = 8'hFF; e = 8'h80; end
        1: begin s = 8'hFF; t = 8'h00; e = 8'h01; end
        2: begin s = START_RESET; t = STOP_RESET; e = ESCAPE_RESET; end
        3: begin s = 8'($urandom); t = s; e = s; end
        default: begin s = 8'($urandom); t = 8'($urandom); e = s; end
      endcase
      write_code(REG_START, s);
      write_code(REG_STOP, t);
      write_code(REG_ESCAPE, e);
      hold_arm = (phase == 1);
      no_idle  = (phase == 2);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < RAND_PER_PHASE) send_random_frame();
      in_valid <= 1'b0;
      drain();
    end

    if (frame_results_due.size() != 0) begin
      $error("%0d expected results never arrived", frame_results_due.size());
      failures++;
    end

    $display("Sent %0d bytes over %0d code settings, with a %0d-cycle output hold-off.",
             bytes_sent, NUM_PHASES + 1, HOLD_CYCLES);
    $display("Checked %0d results: %0d frame data, %0d stray, %0d aborted, %0d missing stop.",
             results_seen, kind_count[KIND_DATA], kind_count[KIND_STRAY],
             kind_count[KIND_CODE], kind_count[KIND_NOSTOP]);
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
